// ----- rtl/fxp_pkg.sv -----
`default_nettype none
package fxp_pkg;
  localparam int FracBits = 8;
  localparam int DW = 32;
  localparam int NumW = DW + FracBits;   // dividend magnitude width
  localparam int Lat = NumW + 2;         // divider stages plus input and output

  typedef enum logic [3:0] {
    K_ADD = 4'd0, K_SUB = 4'd1, K_MUL = 4'd2, K_DIV = 4'd3,
    K_INC = 4'd4, K_DEC = 4'd5, K_LT = 4'd6, K_GT = 4'd7,
    K_LE = 4'd8, K_GE = 4'd9, K_EQ = 4'd10, K_NE = 4'd11,
    K_MAX = 4'd12, K_MIN = 4'd13, K_FROM = 4'd14, K_TOINT = 4'd15
  } kind_t;

  // result of the simple kinds, carried beside the divider
  typedef struct packed {
    kind_t          kind;
    logic [DW-1:0]  res;
    logic           flag;
    logic           neg;
    logic           dz;
  } side_t;
endpackage
`default_nettype wire

// ----- rtl/fxp_mul.sv -----
`default_nettype none
module fxp_mul (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [fxp_pkg::DW-1:0] a,
  input  wire logic [fxp_pkg::DW-1:0] b,
  output logic      [fxp_pkg::DW-1:0] p
);
  import fxp_pkg::*;
  logic signed [2*DW-1:0] prod_r;
  logic signed [2*DW-1:0] sh_r;
  logic signed [DW-1:0] a_r, b_r;
  // three stages: register operands, multiply, shift
  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= a_r * b_r;
      sh_r   <= prod_r >>> FracBits;
    end
  end
  assign p = sh_r[DW-1:0];
endmodule
`default_nettype wire

// ----- rtl/fxp_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per stage.
module fxp_div (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [fxp_pkg::NumW-1:0] num,
  input  wire logic [fxp_pkg::DW-1:0]   den,
  output logic      [fxp_pkg::NumW-1:0] quo
);
  import fxp_pkg::*;
  logic [NumW-1:0] q_r   [NumW+1];
  logic [NumW:0]   rem_r [NumW+1];
  logic [DW-1:0]   d_r   [NumW+1];
  assign q_r[0]   = num;
  assign rem_r[0] = '0;
  assign d_r[0]   = den;
  for (genvar i = 0; i < NumW; i++) begin : g_st
    logic [NumW:0] sh;
    logic [NumW:0] df;
    always_comb begin
      sh = {rem_r[i][NumW-1:0], q_r[i][NumW-1]};
      df = sh - {{(NumW+1-DW){1'b0}}, d_r[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1] <= d_r[i];
        if (!df[NumW]) begin
          rem_r[i+1] <= df;
          q_r[i+1]   <= {q_r[i][NumW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= sh;
          q_r[i+1]   <= {q_r[i][NumW-2:0], 1'b0};
        end
      end
    end
  end
  assign quo = q_r[NumW];
endmodule
`default_nettype wire

// ----- rtl/fixed_point_q24_8_alu_unit.sv -----
`default_nettype none
// Q24.8 fixed-point ALU, stream in, stream out.
// Input transaction: in_tdata = {operand_b, operand_a} (a in bits 31:0,
// b in 63:32), in_tuser = kind (4 bits). Output transaction: out_tdata =
// result (bits 31:0), flag (32), div_by_zero (33), zero-filled to 40 bits.
// Each transaction yields exactly one result, in order.
// Throughput: one transaction per cycle while the output is not stalled.
// Latency from acceptance to out_tvalid is set by the 40-stage restoring divider
// (one quotient bit per stage) plus the input and output registers; all kinds
// share that depth so results stay in order.
// The whole pipeline advances as one: when out_tvalid is high and
// out_tready low, hold every stage; in_tready falls with it, so nothing is
// dropped or repeated. The output register is the skid point.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
module fixed_point_q24_8_alu_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // operand_a, operand_b
  input  wire logic [3:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // result, flag, div_by_zero
);
  import fxp_pkg::*;
  logic adv;
  logic [Lat-1:0] v_r;
  side_t side_r [Lat-1];
  side_t s0;
  logic [DW-1:0] a, b, mul_p;
  logic [NumW-1:0] quo, num;
  logic [DW-1:0] den;
  logic [NumW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic signed [DW-1:0] sa, sb;
  logic [DW-1:0] q32;
  side_t st;
  logic [DW-1:0] res_f;
  logic [39:0] out_r;

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign a = in_tdata[31:0];
  assign b = in_tdata[63:32];
  assign sa = a;
  assign sb = b;

  // simple kinds computed at entry
  always_comb begin
    s0 = '0;
    s0.kind = kind_t'(in_tuser);
    s0.neg  = a[DW-1] ^ b[DW-1];
    unique case (kind_t'(in_tuser))
      K_ADD:   s0.res = a + b;
      K_SUB:   s0.res = a - b;
      K_INC:   s0.res = a + 1'b1;
      K_DEC:   s0.res = a - 1'b1;
      K_LT:    s0.flag = sa < sb;
      K_GT:    s0.flag = sb < sa;
      K_LE:    s0.flag = !(sb < sa);
      K_GE:    s0.flag = !(sa < sb);
      K_EQ:    s0.flag = a == b;
      K_NE:    s0.flag = a != b;
      K_MAX:   s0.res = (sa < sb) ? b : a;
      K_MIN:   s0.res = (sb < sa) ? b : a;
      K_FROM:  s0.res = a << FracBits;
      K_TOINT: s0.res = DW'(sa >>> FracBits);
      K_DIV:   s0.dz = (b == '0);
      default: s0.res = '0;
    endcase
  end

  // magnitudes into the divider, held in the input register
  assign num = {(a[DW-1] ? (~a + 1'b1) : a), {FracBits{1'b0}}};
  assign den = b[DW-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num;
      den_r <= den;
    end
  end

  fxp_mul u_mul (.clk(clk), .en(adv), .a(a), .b(b), .p(mul_p));
  fxp_div u_div (.clk(clk), .en(adv), .num(num_r), .den(den_r), .quo(quo));

  // side channel delay line and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Lat-2:0], in_tvalid};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= s0;
      for (int i = 1; i < Lat-1; i++) side_r[i] <= side_r[i-1];
    end
  end

  // multiplier output captured at its depth, carried to the end
  logic [DW-1:0] mul_d_r [Lat-4];
  always_ff @(posedge clk) begin
    if (adv) begin
      mul_d_r[0] <= mul_p;
      for (int i = 1; i < Lat-4; i++) mul_d_r[i] <= mul_d_r[i-1];
    end
  end

  // select final result
  always_comb begin
    st = side_r[Lat-2];
    q32 = quo[DW-1:0];
    res_f = st.res;
    if (st.kind == K_MUL) res_f = mul_d_r[Lat-5];
    if (st.kind == K_DIV) res_f = st.dz ? '0 : (st.neg ? (~q32 + 1'b1) : q32);
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= {6'd0, st.dz, st.flag, res_f};
  end
  assign out_tvalid = v_r[Lat-1];
  assign out_tdata  = out_r;
endmodule
`default_nettype wire
